// ===== rtl/b64c_pkg.sv =====
package b64c_pkg;

  // Default number of result groups the queue between front and back can hold.
  localparam int QUEUE_DEPTH_DEF = 2;

  // Special characters.
  localparam logic [7:0] PAD_CHAR     = 8'h3D;
  localparam logic [7:0] NEWLINE_CHAR = 8'h0A;

  // Direction codes.
  localparam logic DIR_ENCODE = 1'b0;
  localparam logic DIR_DECODE = 1'b1;

  // One group of up to four result words, as handed from the front to the back.
  typedef struct packed {
    logic [3:0][7:0] bytes;     // word i of the group in bytes[i]
    logic [1:0]      last_idx;  // index of the final word of the group
    logic            valid;     // words carry data
    logic            last;      // final word closes the frame
    logic            err;       // error marker
  } job_t;

  // One result word on the output side.
  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       last;
    logic       err;
  } out_item_t;

  // Alphabet lookup: sextet value to character.
  function automatic logic [7:0] sextet_char(input logic [5:0] s);
    logic [7:0] c;
    if (s < 6'd26) begin
      c = 8'h41 + {2'b00, s};
    end else if (s < 6'd52) begin
      c = 8'h61 + {2'b00, s} - 8'd26;
    end else if (s < 6'd62) begin
      c = 8'h30 + {2'b00, s} - 8'd52;
    end else if (s == 6'd62) begin
      c = 8'h2B;
    end else begin
      c = 8'h2F;
    end
    return c;
  endfunction

  // Reverse lookup: character to sextet; bit 6 set when not in the alphabet.
  function automatic logic [6:0] char_sextet(input logic [7:0] c);
    logic [6:0] v;
    if (c >= 8'h41 && c <= 8'h5A) begin
      v = 7'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      v = 7'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      v = 7'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2B) begin
      v = 7'd62;
    end else if (c == 8'h2F) begin
      v = 7'd63;
    end else begin
      v = 7'd64;
    end
    return v;
  endfunction

endpackage

// ===== rtl/base64_stream_codec.sv =====
// Channel   | Signals                           | Contents
// ----------+-----------------------------------+----------------------------------------
// s (in)    | s_tvalid s_tready s_tdata s_tlast | in_byte, in_last
// m (out)   | m_tvalid m_tready m_tdata m_tlast | out_byte, out_last,
//           | m_tuser                           | tuser: byte_valid, decode_error
// cfg       | cfg_wr_en cfg_wr_data             | direction (0 encode, 1 decode)
//
// The front takes one input word per cycle while the group queue has room.
// The back sends one result word per cycle while m is ready, so encode runs at four output
// words per three input words; decode takes a word every cycle while m is ready.
// A result group passes through the queue and then the output register.
// Reset (rst, synchronous) empties the queue and the output register and selects encode.
// A stall on m holds the output register; the queue then fills and s_tready drops.
module base64_stream_codec #(
  parameter int QUEUE_DEPTH = b64c_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,    // [7:0] in_byte
  input  logic       s_tlast,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,    // [7:0] out_byte
  output logic       m_tlast,
  output logic [1:0] m_tuser,    // [0] byte_valid, [1] decode_error
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data
);
  import b64c_pkg::*;

  job_t      push_job;
  job_t      head;
  logic      push;
  logic      pop;
  logic      empty;
  logic      full;
  out_item_t out_item;

  // Front: group assembly and classification.
  b64c_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_byte     (s_tdata),
    .in_last     (s_tlast),
    .job_push    (push),
    .job         (push_job),
    .queue_full  (full)
  );

  // Queue of result groups.
  b64c_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .empty    (empty),
    .full     (full)
  );

  // Back: one result word per cycle into the output register while a group is queued and m is not stalled.
  b64c_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .queue_empty (empty),
    .pop         (pop),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_item    (out_item)
  );

  assign m_tdata = out_item.data;
  assign m_tlast = out_item.last;
  assign m_tuser = {out_item.err, out_item.valid};

endmodule

// ===== rtl/b64c_queue.sv =====
module b64c_queue #(
  parameter int DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  b64c_pkg::job_t  push_job,
  input  logic            pop,
  output b64c_pkg::job_t  head,
  output logic            empty,
  output logic            full
);
  import b64c_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign empty = (count == '0);
  assign full  = (count == CW'(DEPTH));
  assign head  = slots[rd_ptr];

  // Storage write.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) full |-> !push)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) empty |-> !pop)
    else $error("queue read while empty");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("queue count out of range");
`endif

endmodule

// ===== rtl/b64c_front.sv =====
module b64c_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_wr_en,
  input  logic            cfg_wr_data,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      in_byte,
  input  logic            in_last,
  output logic            job_push,
  output b64c_pkg::job_t  job,
  input  logic            queue_full
);
  import b64c_pkg::*;

  logic        direction;
  logic [23:0] group_bits;
  logic [1:0]  group_fill;
  logic [1:0]  pad_seen;
  logic        dropping;

  logic [23:0] group_bits_next;
  logic [1:0]  group_fill_next;
  logic [1:0]  pad_seen_next;
  logic        dropping_next;

  logic        fire;
  logic        gen_job;
  job_t        err_job;
  job_t        end_job;

  // Encode side signals.
  logic [23:0] enc_bits;
  logic [2:0]  enc_held;
  logic [23:0] enc_aligned;

  // Decode side signals.
  logic [6:0]  dec_sx;
  logic        is_pad;
  logic        is_nl;
  logic [5:0]  dec_val;
  logic [1:0]  pad_new;
  logic [23:0] dec_bits;

  assign in_ready = !queue_full;
  assign fire     = in_valid && in_ready;
  assign job_push = fire && gen_job;

  assign enc_bits = {group_bits[15:0], in_byte};
  assign enc_held = {1'b0, group_fill} + 3'd1;

  assign dec_sx   = char_sextet(in_byte);
  assign is_pad   = (in_byte == PAD_CHAR);
  assign is_nl    = (in_byte == NEWLINE_CHAR);
  assign dec_val  = is_pad ? 6'd0 : dec_sx[5:0];
  assign pad_new  = (is_pad && group_fill >= 2'd2) ? pad_seen + 2'd1 : pad_seen;
  assign dec_bits = {group_bits[17:0], dec_val};

  // Marker words.
  always_comb begin
    err_job          = '0;
    err_job.last     = 1'b1;
    err_job.err      = 1'b1;
    end_job          = '0;
    end_job.last     = 1'b1;
  end

  // Align a partial encode group to the top of the 24 bits.
  always_comb begin
    case (enc_held)
      3'd1:    enc_aligned = {enc_bits[7:0], 16'h0000};
      3'd2:    enc_aligned = {enc_bits[15:0], 8'h00};
      default: enc_aligned = enc_bits;
    endcase
  end

  // Per-item state update and result group.
  always_comb begin
    group_bits_next = group_bits;
    group_fill_next = group_fill;
    pad_seen_next   = pad_seen;
    dropping_next   = dropping;
    gen_job         = 1'b0;
    job             = '0;

    if (direction == DIR_ENCODE) begin
      if (enc_held < 3'd3 && !in_last) begin
        group_bits_next = enc_bits;
        group_fill_next = enc_held[1:0];
      end else begin
        gen_job       = 1'b1;
        job.valid     = 1'b1;
        job.last      = in_last;
        job.last_idx  = 2'd3;
        job.bytes[0]  = sextet_char(enc_aligned[23:18]);
        job.bytes[1]  = sextet_char(enc_aligned[17:12]);
        job.bytes[2]  = (enc_held >= 3'd2) ? sextet_char(enc_aligned[11:6]) : PAD_CHAR;
        job.bytes[3]  = (enc_held >= 3'd3) ? sextet_char(enc_aligned[5:0]) : PAD_CHAR;
        group_bits_next = '0;
        group_fill_next = '0;
        pad_seen_next   = '0;
      end
    end else if (dropping) begin
      if (in_last) begin
        dropping_next = 1'b0;
      end
    end else if (is_nl) begin
      if (in_last) begin
        gen_job         = 1'b1;
        job             = (group_fill == 2'd0) ? end_job : err_job;
        group_bits_next = '0;
        group_fill_next = '0;
        pad_seen_next   = '0;
      end
    end else if (!is_pad && dec_sx[6]) begin
      // Character outside the alphabet.
      gen_job         = 1'b1;
      job             = err_job;
      group_bits_next = '0;
      group_fill_next = '0;
      pad_seen_next   = '0;
      dropping_next   = !in_last;
    end else if (group_fill != 2'd3) begin
      if (in_last) begin
        // Frame ends inside a quad.
        gen_job         = 1'b1;
        job             = err_job;
        group_bits_next = '0;
        group_fill_next = '0;
        pad_seen_next   = '0;
      end else begin
        group_bits_next = dec_bits;
        group_fill_next = group_fill + 2'd1;
        pad_seen_next   = pad_new;
      end
    end else begin
      // Quad complete: one byte fewer for each pad in the back half.
      gen_job      = 1'b1;
      job.valid    = 1'b1;
      job.last     = in_last;
      job.bytes[0] = dec_bits[23:16];
      job.bytes[1] = dec_bits[15:8];
      job.bytes[2] = dec_bits[7:0];
      case (pad_new)
        2'd0:    job.last_idx = 2'd2;
        2'd1:    job.last_idx = 2'd1;
        default: job.last_idx = 2'd0;
      endcase
      group_bits_next = '0;
      group_fill_next = '0;
      pad_seen_next   = '0;
    end
  end

  // State registers; a direction write restarts the group assembly in the front.
  always_ff @(posedge clk) begin
    if (rst) begin
      direction  <= DIR_ENCODE;
      group_bits <= '0;
      group_fill <= '0;
      pad_seen   <= '0;
      dropping   <= 1'b0;
    end else if (cfg_wr_en) begin
      direction  <= cfg_wr_data;
      group_bits <= '0;
      group_fill <= '0;
      pad_seen   <= '0;
      dropping   <= 1'b0;
    end else if (fire) begin
      group_bits <= group_bits_next;
      group_fill <= group_fill_next;
      pad_seen   <= pad_seen_next;
      dropping   <= dropping_next;
    end
  end

`ifndef SYNTHESIS
  a_enc_fill: assert property (@(posedge clk) disable iff (rst)
    (direction == DIR_ENCODE) |-> (group_fill != 2'd3))
    else $error("encode group holds more than two bytes");
  a_pad_count: assert property (@(posedge clk) disable iff (rst) pad_seen != 2'd3)
    else $error("pad count beyond two");
  a_enc_idle_flags: assert property (@(posedge clk) disable iff (rst)
    (direction == DIR_ENCODE) |-> (!dropping && pad_seen == 2'd0))
    else $error("decode state active while encoding");
`endif

endmodule

// ===== rtl/b64c_back.sv =====
module b64c_back (
  input  logic                 clk,
  input  logic                 rst,
  input  b64c_pkg::job_t       head,
  input  logic                 queue_empty,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output b64c_pkg::out_item_t  out_item
);
  import b64c_pkg::*;

  logic [1:0] idx;
  logic       adv;
  logic       emit;
  logic       at_end;

  assign adv    = !out_valid || out_ready;
  assign emit   = adv && !queue_empty;
  assign at_end = (idx == head.last_idx);
  assign pop    = emit && at_end;

  // Word index within the group at the head of the queue.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (emit) begin
      idx <= at_end ? 2'd0 : idx + 2'd1;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= !queue_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_item.data  <= head.bytes[idx];
      out_item.valid <= head.valid;
      out_item.last  <= head.last && at_end;
      out_item.err   <= head.err;
    end
  end

`ifndef SYNTHESIS
  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    !queue_empty |-> (idx <= head.last_idx))
    else $error("word index past end of group");
  a_idx_idle: assert property (@(posedge clk) disable iff (rst)
    queue_empty |-> (idx == 2'd0))
    else $error("word index left over with empty queue");
  a_err_marker: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.err) |-> (out_item.last && !out_item.valid))
    else $error("error marker not a bare closing word");
`endif

endmodule
